/* rtl/dct8_pkg.sv */
// Shared constants, codes and coefficient tables of the 8-point integer DCT.
package dct8_pkg;

  localparam int DATA_W  = 16;
  localparam int SHIFT_W = 5;
  localparam int NUM_PT  = 8;
  localparam int COEF_W  = 8;

  // Transform direction codes
  localparam logic MODE_FWD = 1'b0;
  localparam logic MODE_INV = 1'b1;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [COEF_W-1:0] coef_t;

  // DC row weight of the 8x8 matrix (rows 0 and 4)
  localparam coef_t DC_COEF = 8'sd64;

  // Even-odd part (rows 2 and 6), symmetric 2x2
  localparam coef_t EVEN_COEF [2][2] = '{
    '{8'sd83,  8'sd36},
    '{8'sd36, -8'sd83}
  };

  // Odd part (rows 1, 3, 5, 7), symmetric 4x4
  localparam coef_t ODD_COEF [4][4] = '{
    '{8'sd89,  8'sd75,  8'sd50,  8'sd18},
    '{8'sd75, -8'sd18, -8'sd89, -8'sd50},
    '{8'sd50, -8'sd89,  8'sd18,  8'sd75},
    '{8'sd18, -8'sd50,  8'sd75, -8'sd89}
  };

endpackage

/* rtl/dct8_if.sv */
// Valid/ready channel interfaces for the input vector and the result vector.
interface dct8_in_if;
  import dct8_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [SHIFT_W-1:0]   round_shift;
  logic signed [DATA_W-1:0] in_0;
  logic signed [DATA_W-1:0] in_1;
  logic signed [DATA_W-1:0] in_2;
  logic signed [DATA_W-1:0] in_3;
  logic signed [DATA_W-1:0] in_4;
  logic signed [DATA_W-1:0] in_5;
  logic signed [DATA_W-1:0] in_6;
  logic signed [DATA_W-1:0] in_7;

  modport source (
    output valid, mode, round_shift, in_0, in_1, in_2, in_3, in_4, in_5, in_6, in_7,
    input  ready
  );
  modport sink (
    input  valid, mode, round_shift, in_0, in_1, in_2, in_3, in_4, in_5, in_6, in_7,
    output ready
  );
endinterface

interface dct8_out_if;
  import dct8_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [DATA_W-1:0] out_0;
  logic signed [DATA_W-1:0] out_1;
  logic signed [DATA_W-1:0] out_2;
  logic signed [DATA_W-1:0] out_3;
  logic signed [DATA_W-1:0] out_4;
  logic signed [DATA_W-1:0] out_5;
  logic signed [DATA_W-1:0] out_6;
  logic signed [DATA_W-1:0] out_7;

  modport source (
    output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
    input  ready
  );
  modport sink (
    input  valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
    output ready
  );
endinterface

/* rtl/dct8_bfly.sv */
// Even/odd partial butterfly shared by the forward and the inverse 8-point transform.
module dct8_bfly #(
  parameter int SampleW = 16,
  parameter int AccW    = 26
) (
  input  logic                      mode_i,
  input  logic signed [SampleW-1:0] x_i [8],
  output logic signed [AccW-1:0]    y_o [8]
);
  import dct8_pkg::*;

  logic signed [AccW-1:0] xe   [8];
  logic signed [AccW-1:0] sum4 [4];
  logic signed [AccW-1:0] v    [4];
  logic signed [AccW-1:0] od   [4];
  logic signed [AccW-1:0] ev   [4];
  logic signed [AccW-1:0] dc_a, dc_b, c0, c1;
  logic signed [AccW-1:0] p, q, r0, r1;

  always_comb begin
    // Widen samples to the accumulator width
    for (int k = 0; k < 8; k++) begin
      xe[k] = AccW'(x_i[k]);
    end

    // Select butterfly operands: folded samples or spread coefficients
    for (int k = 0; k < 4; k++) begin
      sum4[k] = xe[k] + xe[7-k];
    end
    if (mode_i == MODE_INV) begin
      dc_a = xe[0];
      dc_b = xe[4];
      c0   = xe[2];
      c1   = xe[6];
      for (int k = 0; k < 4; k++) begin
        v[k] = xe[2*k+1];
      end
    end else begin
      dc_a = sum4[0] + sum4[3];
      dc_b = sum4[1] + sum4[2];
      c0   = sum4[0] - sum4[3];
      c1   = sum4[1] - sum4[2];
      for (int k = 0; k < 4; k++) begin
        v[k] = xe[k] - xe[7-k];
      end
    end

    // DC and even-odd products
    p  = (dc_a + dc_b) * DC_COEF;
    q  = (dc_a - dc_b) * DC_COEF;
    r0 = c0 * EVEN_COEF[0][0] + c1 * EVEN_COEF[0][1];
    r1 = c0 * EVEN_COEF[1][0] + c1 * EVEN_COEF[1][1];

    // Odd products, one independent dot product per row
    for (int k = 0; k < 4; k++) begin
      od[k] = '0;
      for (int m = 0; m < 4; m++) begin
        od[k] = od[k] + v[m] * ODD_COEF[k][m];
      end
    end

    // Recombine: interleave for forward, final butterfly for inverse
    ev[0] = p + r0;
    ev[3] = p - r0;
    ev[1] = q + r1;
    ev[2] = q - r1;
    if (mode_i == MODE_INV) begin
      for (int k = 0; k < 4; k++) begin
        y_o[k]   = ev[k] + od[k];
        y_o[7-k] = ev[k] - od[k];
      end
    end else begin
      y_o[0] = p;
      y_o[4] = q;
      y_o[2] = r0;
      y_o[6] = r1;
      for (int k = 0; k < 4; k++) begin
        y_o[2*k+1] = od[k];
      end
    end
  end

endmodule

/* rtl/integer_dct8_forward_inverse_top.sv */
// Top level of the pipelined 8-point integer DCT / inverse DCT.
//
//   channel | dir | handshake       | word
//   --------+-----+-----------------+-----------------------------------------
//   in_if   | in  | valid/ready     | mode, round_shift, in_0 .. in_7
//   out_if  | out | valid/ready     | out_0 .. out_7
//
// One vector enters per cycle unless out_if stalls; an accepted word passes the
// input register, the butterfly-to-accumulator register and the rounded output
// register before it leaves on out_if. The butterfly and the rounding shifter
// set the stage depth.
// Reset clears only the stage valid bits. A stall on out_if backs up stage by
// stage; in_if.ready drops only once all three stages hold a word.
module integer_dct8_forward_inverse_top #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dct8_in_if.sink    in_if,
  dct8_out_if.source out_if
);
  import dct8_pkg::*;

  localparam int AccW = SAMPLE_WIDTH + 10;
  localparam int RndW = (AccW > 30) ? AccW + 2 : 32;

  // Round half up, shift right arithmetically, wrap to the sample width
  function automatic word_t round_pack(input logic signed [AccW-1:0] acc,
                                       input logic [SHIFT_W-1:0] sh);
    logic        [RndW-1:0]         ofs;
    logic signed [RndW-1:0]         sum;
    logic signed [RndW-1:0]         res;
    logic signed [SAMPLE_WIDTH-1:0] trunc;
    ofs   = ({{(RndW-1){1'b0}}, 1'b1} << sh) >> 1;
    sum   = RndW'(acc) + $signed(ofs);
    res   = sum >>> sh;
    trunc = res[SAMPLE_WIDTH-1:0];
    return DATA_W'(trunc);
  endfunction

  logic signed [DATA_W-1:0]       in_vec [8];

  logic                           s1_vld_q, s1_vld_d;
  logic                           s1_mode_q;
  logic [SHIFT_W-1:0]             s1_shift_q;
  logic signed [SAMPLE_WIDTH-1:0] s1_x_q [8];

  logic                           s2_vld_q, s2_vld_d;
  logic [SHIFT_W-1:0]             s2_shift_q;
  logic signed [AccW-1:0]         s2_acc_q [8];
  logic signed [AccW-1:0]         acc_d [8];

  logic                           out_vld_q, out_vld_d;
  word_t                          out_y_q [8];

  logic in_ready, in_acc, s2_ld, out_ld;

  // Gather the input word into a vector
  assign in_vec[0] = in_if.in_0;
  assign in_vec[1] = in_if.in_1;
  assign in_vec[2] = in_if.in_2;
  assign in_vec[3] = in_if.in_3;
  assign in_vec[4] = in_if.in_4;
  assign in_vec[5] = in_if.in_5;
  assign in_vec[6] = in_if.in_6;
  assign in_vec[7] = in_if.in_7;

  // Advance a stage when its successor is empty or moving on
  assign out_ld   = s2_vld_q && (!out_vld_q || out_if.ready);
  assign s2_ld    = s1_vld_q && (!s2_vld_q || out_ld);
  assign in_ready = !s1_vld_q || s2_ld;
  assign in_acc   = in_if.valid && in_ready;

  assign s1_vld_d  = in_acc ? 1'b1 : (s2_ld ? 1'b0 : s1_vld_q);
  assign s2_vld_d  = s2_ld ? 1'b1 : (out_ld ? 1'b0 : s2_vld_q);
  assign out_vld_d = out_ld ? 1'b1 : (out_if.ready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s2_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Butterfly between the input register and the accumulator register
  dct8_bfly #(
    .SampleW (SAMPLE_WIDTH),
    .AccW    (AccW)
  ) u_bfly (
    .mode_i (s1_mode_q),
    .x_i    (s1_x_q),
    .y_o    (acc_d)
  );

  // Load payload registers on stage advance
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q  <= in_if.mode;
      s1_shift_q <= in_if.round_shift;
      for (int k = 0; k < 8; k++) begin
        s1_x_q[k] <= in_vec[k][SAMPLE_WIDTH-1:0];
      end
    end
    if (s2_ld) begin
      s2_shift_q <= s1_shift_q;
      for (int k = 0; k < 8; k++) begin
        s2_acc_q[k] <= acc_d[k];
      end
    end
    if (out_ld) begin
      for (int k = 0; k < 8; k++) begin
        out_y_q[k] <= round_pack(s2_acc_q[k], s2_shift_q);
      end
    end
  end

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_vld_q;
  assign out_if.out_0 = out_y_q[0];
  assign out_if.out_1 = out_y_q[1];
  assign out_if.out_2 = out_y_q[2];
  assign out_if.out_3 = out_y_q[3];
  assign out_if.out_4 = out_y_q[4];
  assign out_if.out_5 = out_y_q[5];
  assign out_if.out_6 = out_y_q[6];
  assign out_if.out_7 = out_y_q[7];

  // An accepted word always lands in the input register
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.valid && in_if.ready |=> s1_vld_q)
    else $error("accepted word missing from input stage");

  // A blocked input stage keeps its word
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !s2_ld && !in_if.valid |=> s1_vld_q && $stable(s1_mode_q)
      && $stable(s1_shift_q))
    else $error("input stage lost a stalled word");

  // A blocked accumulator stage keeps its word
  a_s2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_vld_q && !out_ld |=> s2_vld_q && $stable(s2_shift_q))
    else $error("accumulator stage lost a stalled word");

  // An empty input stage never stalls the source
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_vld_q |-> in_if.ready)
    else $error("ready low with empty input stage");

  // A taken result with nothing behind it leaves the output empty
  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.ready && !s2_vld_q |=> !out_if.valid)
    else $error("result repeated after hand-off");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the forward/inverse 8-point integer DCT top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dct8_pkg::*;

  // Integer DCT basis, one row per frequency
  localparam int DCT_BASIS [8][8] = '{
    '{64,  64,  64,  64,  64,  64,  64,  64},
    '{89,  75,  50,  18, -18, -50, -75, -89},
    '{83,  36, -36, -83, -83, -36,  36,  83},
    '{75, -18, -89, -50,  50,  89,  18, -75},
    '{64, -64, -64,  64,  64, -64, -64,  64},
    '{50, -89,  18,  75, -75, -18,  89, -50},
    '{36, -83,  83, -36, -36,  83, -83,  36},
    '{18, -50,  75, -89,  89, -75,  50, -18}
  };

  localparam int NUM_RANDOM = 1250;

  typedef struct packed {
    logic                 mode;
    logic [SHIFT_W-1:0]   shift;
    word_t [NUM_PT-1:0]   elem;
  } vector_word_t;

  typedef struct packed {
    word_t [NUM_PT-1:0]   elem;
  } result_word_t;

  // Predict each transform and match results in order
  class dct_scoreboard;
    result_word_t expected_rows [$];
    int           errors;

    function result_word_t transform(vector_word_t v);
      result_word_t r;
      longint       acc;
      longint       x [NUM_PT];
      int           c;
      for (int i = 0; i < NUM_PT; i++) begin
        x[i] = longint'($signed(v.elem[i]));
      end
      for (int i = 0; i < NUM_PT; i++) begin
        acc = 0;
        for (int j = 0; j < NUM_PT; j++) begin
          c = (v.mode == MODE_INV) ? DCT_BASIS[j][i] : DCT_BASIS[i][j];
          acc += longint'(c) * x[j];
        end
        // round half up, then arithmetic shift and wrap to the word width
        if (v.shift != 0) begin
          acc += longint'(1) << (v.shift - 1);
        end
        acc = acc >>> v.shift;
        r.elem[i] = acc[DATA_W-1:0];
      end
      return r;
    endfunction

    function void note_vector(vector_word_t v);
      expected_rows.push_back(transform(v));
    endfunction

    function void check_result(result_word_t got);
      result_word_t want;
      if (expected_rows.size() == 0) begin
        $error("result word with no vector outstanding");
        errors++;
        return;
      end
      want = expected_rows.pop_front();
      for (int k = 0; k < NUM_PT; k++) begin
        if (got.elem[k] !== want.elem[k]) begin
          $error("out_%0d: expected %0d, actual %0d", k, want.elem[k], got.elem[k]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_rows.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  dct8_in_if  in_ch ();
  dct8_out_if out_ch ();

  dct_scoreboard book = new();

  bit src_calm;
  bit sink_calm;

  integer_dct8_forward_inverse_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // 12 ns clock, first rising edge after time zero
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // Mix of full-range, small, extreme and near-zero samples
  function automatic word_t pick_sample();
    case ($urandom_range(0, 5))
      0: return word_t'($urandom);
      1: return word_t'($signed($urandom_range(0, 511)) - 256);
      2: return word_t'(16'sh7FFF);
      3: return word_t'(16'sh8000);
      4: return word_t'($signed($urandom_range(0, 2)) - 1);
      default: return word_t'($urandom);
    endcase
  endfunction

  // Mostly the normal shift range, now and then zero or a large shift
  function automatic logic [SHIFT_W-1:0] pick_shift();
    case ($urandom_range(0, 9))
      7: return '0;
      8: return SHIFT_W'($urandom_range(21, 31));
      9: return SHIFT_W'($urandom_range(0, 31));
      default: return SHIFT_W'($urandom_range(1, 20));
    endcase
  endfunction

  // Present one vector after a random gap and hold it until accepted
  task automatic send_vector(vector_word_t v);
    int gap;
    gap = draw_wait(src_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_ch.in_0  <= word_t'($urandom);
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= v.mode;
    in_ch.round_shift <= v.shift;
    in_ch.in_0        <= v.elem[0];
    in_ch.in_1        <= v.elem[1];
    in_ch.in_2        <= v.elem[2];
    in_ch.in_3        <= v.elem[3];
    in_ch.in_4        <= v.elem[4];
    in_ch.in_5        <= v.elem[5];
    in_ch.in_6        <= v.elem[6];
    in_ch.in_7        <= v.elem[7];
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    book.note_vector(v);
  endtask

  // Vector of two alternating values
  task automatic send_fill(logic mode, logic [SHIFT_W-1:0] shift, word_t a, word_t b);
    vector_word_t v;
    v.mode  = mode;
    v.shift = shift;
    for (int k = 0; k < NUM_PT; k++) begin
      v.elem[k] = k[0] ? b : a;
    end
    send_vector(v);
  endtask

  // Stimulus and end of run
  initial begin : stimulus
    vector_word_t v;
    rst_ni            <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.mode        <= MODE_FWD;
    in_ch.round_shift <= '0;
    in_ch.in_0        <= '0;
    in_ch.in_1        <= '0;
    in_ch.in_2        <= '0;
    in_ch.in_3        <= '0;
    in_ch.in_4        <= '0;
    in_ch.in_5        <= '0;
    in_ch.in_6        <= '0;
    in_ch.in_7        <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, both directions, zero and large shifts, wrapping sums
    send_fill(MODE_FWD, 5'd0,  16'sh0000, 16'sh0000);
    send_fill(MODE_FWD, 5'd0,  16'sh7FFF, 16'sh7FFF);
    send_fill(MODE_INV, 5'd31, 16'sh8000, 16'sh8000);
    send_fill(MODE_FWD, 5'd1,  16'sh7FFF, 16'sh8000);
    send_fill(MODE_INV, 5'd1,  16'sh8000, 16'sh7FFF);
    send_fill(MODE_FWD, 5'd20, 16'sh5555, 16'shAAAA);
    send_fill(MODE_INV, 5'd21, 16'shAAAA, 16'sh5555);
    send_fill(MODE_FWD, 5'd31, 16'sh7FFF, 16'sh7FFF);
    send_fill(MODE_INV, 5'd0,  16'sh7FFF, 16'sh7FFF);
    send_fill(MODE_FWD, 5'd12, 16'shFFFF, 16'shFFFF);

    // Directed: single impulses pick out rows and columns of the basis
    for (int k = 0; k < NUM_PT; k++) begin
      v.mode  = k[0] ? MODE_INV : MODE_FWD;
      v.shift = 5'd7;
      v.elem  = '0;
      v.elem[k] = k[1] ? word_t'(16'sh8000) : word_t'(16'sh7FFF);
      send_vector(v);
    end

    // Random vectors with occasional stretches of back-to-back traffic
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if ($urandom_range(0, 59) == 0) src_calm = !src_calm;
      v.mode  = $urandom_range(0, 1) ? MODE_INV : MODE_FWD;
      v.shift = pick_shift();
      for (int k = 0; k < NUM_PT; k++) begin
        v.elem[k] = pick_sample();
      end
      send_vector(v);
    end
    in_ch.valid <= 1'b0;

    // Drain, then allow for the pipeline depth
    while (book.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Result side: random back-pressure, check each accepted word
  initial begin : result_sink
    int           stall;
    result_word_t got;
    out_ch.ready <= 1'b0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.elem[0] = out_ch.out_0;
        got.elem[1] = out_ch.out_1;
        got.elem[2] = out_ch.out_2;
        got.elem[3] = out_ch.out_3;
        got.elem[4] = out_ch.out_4;
        got.elem[5] = out_ch.out_5;
        got.elem[6] = out_ch.out_6;
        got.elem[7] = out_ch.out_7;
        book.check_result(got);
        if ($urandom_range(0, 59) == 0) sink_calm = !sink_calm;
        stall = draw_wait(sink_calm);
      end else if (stall > 0) begin
        stall--;
      end
      out_ch.ready <= rst_ni && (stall == 0);
    end
  end

  // Watchdog
  initial begin : watchdog
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
